/* sv/smcsr_pkg.sv */
package smcsr_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_BUILD  = 2'd2;
    localparam logic [1:0] CMD_LOOKUP = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_BUILD = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  row_index;
        logic [7:0]  col_index;
        logic [63:0] value;
    } t_smcsr_in;

    typedef struct packed {
        logic [63:0] result_value;
        logic        found;
        logic [1:0]  status;
    } t_smcsr_out;

endpackage

/* sv/smcsr_if.sv */
interface smcsr_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/sparse_matrix_csr_store_unit.sv */
// Channel | Dir | Payload
// i_cmd   | in  | cmd, row_index, col_index, value
// o_res   | out | result_value, found, status
//
// Clear and add go from the accept cycle to the output state, which holds the result.
// A build runs an insertion sort over the entry memory, one access per cycle, then
// fills in the row starts.
// A lookup reads its row start and the next row start, then scans that row's entries in turn.
// Reset (synchronous, low) clears the count, build flag and state machine.
// A result waits in the output register; no new transfer is taken until it leaves.
module sparse_matrix_csr_store_unit
    import smcsr_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    smcsr_if.sink   i_cmd,
    smcsr_if.source o_res
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS + 1) : 1;
    localparam int KW = 16;

    localparam logic [3:0] S_IDLE = 4'd0, S_OUT = 4'd1, S_SO_RD = 4'd2,
        S_SO_CHK = 4'd3, S_SO_CMP = 4'd4, S_SO_PUT = 4'd5, S_RS = 4'd6,
        S_RS_CHK = 4'd7, S_LK_A = 4'd8, S_LK_B = 4'd9, S_LK_C = 4'd10,
        S_LK_RD = 4'd11, S_LK_CHK = 4'd12, S_SO_NXT = 4'd13;

    typedef struct packed {
        logic [7:0]  row;
        logic [7:0]  col;
        logic [63:0] val;
    } t_entry;

    // entry memory and row-start memory
    t_entry      ent_mem [MAX_ENTRIES];
    logic [CW-1:0] rs_mem [MAX_ROWS + 1];

    logic          ent_we;
    logic [AW-1:0] ent_wa, ent_ra;
    t_entry        ent_wd, r_ent_q;
    logic          rs_we;
    logic [RW-1:0] rs_wa, rs_ra;
    logic [CW-1:0] rs_wd, r_rs_q;

    always_ff @(posedge i_clk) begin
        if (ent_we) ent_mem[ent_wa] <= ent_wd;
        r_ent_q <= ent_mem[ent_ra];
        if (rs_we) rs_mem[rs_wa] <= rs_wd;
        r_rs_q <= rs_mem[rs_ra];
    end

    logic [3:0]    r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_built, n_built;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k, r_end, n_end;
    logic [RW:0]   r_r, n_r;
    t_entry        r_hold, n_hold;
    t_smcsr_in     r_cmd, n_cmd;
    t_smcsr_out    r_out, n_out;

    wire [KW-1:0] hold_key = {r_hold.row, r_hold.col};
    wire [KW-1:0] q_key    = {r_ent_q.row, r_ent_q.col};
    wire in_rng = ({24'd0, r_cmd.row_index} < MAX_ROWS) && ({24'd0, r_cmd.col_index} < MAX_COLS);

    logic [CW-1:0] rs_mem_end;
    assign rs_mem_end = r_rs_q;

    assign i_cmd.ready = (r_st == S_IDLE);
    assign o_res.valid = (r_st == S_OUT);
    assign o_res.data  = r_out;

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_built = r_built;
        n_i = r_i; n_j = r_j; n_k = r_k; n_end = r_end; n_r = r_r;
        n_hold = r_hold; n_cmd = r_cmd; n_out = r_out;
        ent_we = 1'b0; ent_wa = '0; ent_wd = r_hold; ent_ra = '0;
        rs_we = 1'b0; rs_wa = '0; rs_wd = r_k; rs_ra = '0;
        unique case (r_st)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd = i_cmd.data;
                    n_out = '0;
                    unique case (i_cmd.data.cmd)
                        CMD_CLEAR: begin
                            n_cnt = '0; n_built = 1'b0; n_st = S_OUT;
                        end
                        CMD_ADD: begin
                            n_st = S_OUT;
                            if (r_cnt >= CW'(MAX_ENTRIES)) begin
                                n_out.status = ST_FULL;
                            end else if (({24'd0, i_cmd.data.row_index} < MAX_ROWS)
                                && ({24'd0, i_cmd.data.col_index} < MAX_COLS)) begin
                                ent_we = 1'b1;
                                ent_wa = r_cnt[AW-1:0];
                                ent_wd = '{i_cmd.data.row_index, i_cmd.data.col_index,
                                           i_cmd.data.value};
                                n_cnt = r_cnt + 1'b1;
                                n_built = 1'b0;
                            end
                        end
                        CMD_BUILD: begin
                            n_i = CW'(1); n_st = S_SO_RD;
                        end
                        CMD_LOOKUP: begin
                            if (!r_built) begin
                                n_out.status = ST_NO_BUILD; n_st = S_OUT;
                            end else begin
                                n_st = S_LK_A;
                            end
                        end
                    endcase
                end
            end
            S_OUT: if (o_res.ready) n_st = S_IDLE;
            // insertion sort: read entry i into hold, shift larger ones up
            S_SO_RD: begin
                if (r_i >= r_cnt) begin
                    n_r = '0; n_k = '0; n_st = S_RS;
                end else begin
                    ent_ra = r_i[AW-1:0]; n_st = S_SO_NXT;
                end
            end
            S_SO_NXT: begin
                n_hold = r_ent_q; n_j = r_i; n_st = S_SO_CHK;
            end
            S_SO_CHK: begin
                if (r_j == '0) n_st = S_SO_PUT;
                else begin
                    ent_ra = AW'(r_j - 1'b1); n_st = S_SO_CMP;
                end
            end
            S_SO_CMP: begin
                if (q_key > hold_key) begin
                    ent_we = 1'b1; ent_wa = r_j[AW-1:0]; ent_wd = r_ent_q;
                    n_j = r_j - 1'b1; n_st = S_SO_CHK;
                end else n_st = S_SO_PUT;
            end
            S_SO_PUT: begin
                ent_we = 1'b1; ent_wa = r_j[AW-1:0]; ent_wd = r_hold;
                n_i = r_i + 1'b1; n_st = S_SO_RD;
            end
            // row starts: advance k while row[k] < r
            S_RS: begin
                if (r_k < r_cnt) begin
                    ent_ra = r_k[AW-1:0]; n_st = S_RS_CHK;
                end else begin
                    rs_we = 1'b1; rs_wa = r_r[RW-1:0];
                    if (r_r == (RW+1)'(MAX_ROWS)) begin
                        n_built = 1'b1; n_out = '0; n_st = S_OUT;
                    end else n_r = r_r + 1'b1;
                end
            end
            S_RS_CHK: begin
                if ({{(RW+1){1'b0}}, r_ent_q.row} < {8'd0, r_r}) begin
                    n_k = r_k + 1'b1;
                end else begin
                    rs_we = 1'b1; rs_wa = r_r[RW-1:0];
                    if (r_r == (RW+1)'(MAX_ROWS)) begin
                        n_built = 1'b1; n_out = '0; n_st = S_OUT;
                    end else n_r = r_r + 1'b1;
                end
                if (n_st == S_RS_CHK) n_st = S_RS;
            end
            S_LK_A: begin
                if (!in_rng) n_st = S_OUT;
                else begin
                    rs_ra = RW'(r_cmd.row_index); n_st = S_LK_B;
                end
            end
            // row start r returns here; request row start r+1
            S_LK_B: begin
                n_k = r_rs_q;
                rs_ra = RW'({1'b0, r_cmd.row_index} + 9'd1); n_st = S_LK_C;
            end
            S_LK_C: begin
                n_st = S_LK_RD;
            end
            S_LK_RD: begin
                if (r_k >= r_end) n_st = S_OUT;
                else begin
                    ent_ra = r_k[AW-1:0]; n_st = S_LK_CHK;
                end
            end
            S_LK_CHK: begin
                if (r_ent_q.col == r_cmd.col_index) begin
                    n_out.result_value = r_ent_q.val; n_out.found = 1'b1;
                    n_st = S_OUT;
                end else begin
                    n_k = r_k + 1'b1; n_st = S_LK_RD;
                end
            end
            default: n_st = S_IDLE;
        endcase
        // end pointer captured once row start r+1 returns
        if (r_st == S_LK_C) n_end = rs_mem_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_built <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_built <= n_built;
        end
        r_i <= n_i; r_j <= n_j; r_k <= n_k; r_end <= n_end; r_r <= n_r;
        r_hold <= n_hold; r_cmd <= n_cmd; r_out <= n_out;
    end
endmodule
